FILE: rtl/mr_pkg.sv
// Shared types, constants and command codes of the Montgomery reduction block.
package mr_pkg;

  // Field and register widths
  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned CfgWidth        = 16;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned OutDataWidth    = 24;
  localparam int unsigned StatusWidth     = 2;

  // Configuration register indexes
  typedef enum logic {
    REG_RADIX   = 1'b0,
    REG_MODULUS = 1'b1
  } cfg_reg_e;

  // Result status codes
  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_COPRIME = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_NN,
    OP_GCD_SEED,
    OP_DIV_GCD,
    OP_GCD_STEP,
    OP_GCD_END,
    OP_GCD_FAIL,
    OP_ERR_COPRIME,
    OP_ERR_RANGE,
    OP_DIV_T,
    OP_MUL_M,
    OP_DIV_M,
    OP_MUL_N,
    OP_DIV_S,
    OP_FINISH,
    OP_EMIT
  } op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NN,
    ST_NN_WAIT,
    ST_GCD_TEST,
    ST_GCD_WAIT,
    ST_GCD_END,
    ST_GCD_FAIL,
    ST_CHECK,
    ST_T_WAIT,
    ST_DIV_M,
    ST_M_WAIT,
    ST_DIV_S,
    ST_S_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cache_ready;
    logic coprime;
    logic operand_zero;
    logic r1_zero;
    logic t_high;
  } dp_status_t;

endpackage

FILE: rtl/mr_div.sv
// Restoring divider, one quotient bit per cycle.
module mr_div import mr_pkg::*; #(
  parameter int unsigned OW = OperandWidthDef,
  parameter int unsigned DW = 2 * OperandWidthDef + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [OW-1:0] divisor_i,
  output logic [DW-1:0] quot_o,
  output logic [OW-1:0] rem_o,
  output logic          done_o
);

  localparam int unsigned CntW = $clog2(DW);

  logic          busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0] dividend_q, quot_q;
  logic [OW-1:0] divisor_q, rem_q;
  logic [OW:0]   shift, diff;
  logic          ge;

  // Trial subtraction of the next partial remainder
  always_comb begin
    shift = {rem_q, dividend_q[DW-1]};
    ge    = (shift >= {1'b0, divisor_q});
    diff  = shift - {1'b0, divisor_q};
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dividend_q <= dividend_i;
      divisor_q  <= divisor_i;
      rem_q      <= '0;
    end else if (busy_q) begin
      rem_q      <= ge ? diff[OW-1:0] : shift[OW-1:0];
      dividend_q <= {dividend_q[DW-2:0], 1'b0};
      quot_q     <= {quot_q[DW-2:0], ge};
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

FILE: rtl/mr_datapath.sv
// Datapath: configuration, inverse cache, Euclid state, products and result register.
module mr_datapath import mr_pkg::*; #(
  parameter int unsigned OW = OperandWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_addr_i,
  input  logic [CfgWidth-1:0]     cfg_wdata_i,
  input  logic [ValueWidth-1:0]   value_t_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  output logic [CfgWidth-1:0]     reduced_o,
  output status_e                 result_status_o
);

  localparam int unsigned DW = 2 * OW + 1;
  localparam int unsigned CW = OW + 2;
  localparam int unsigned PW = 2 * OW;
  localparam int unsigned QW = OW + CW + 1;

  logic [OW-1:0]   radix_q, modulus_q;
  logic            cache_ready_q, coprime_q;
  logic [OW-1:0]   inv_q;
  logic [ValueWidth-1:0] tv_q;
  logic [2*OW-1:0] rn_q, prod_q;
  logic [OW-1:0]   r0_q, r1_q, lo_q, hi_q, res_q, out_q;
  logic signed [CW-1:0] c0_q, c1_q;
  status_e         stat_q, out_stat_q;

  logic            div_start, div_done;
  logic [DW-1:0]   div_dividend, div_quot;
  logic [OW-1:0]   div_divisor, div_rem;

  logic signed [OW+CW:0] qc;
  logic signed [CW-1:0]  c_next, rr_s, v0, v1;
  logic [OW-1:0]   inv_calc;
  logic [OW:0]     t_sum, t_fix;

  // Select divider operands
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = radix_q;
    unique case (cmd_i.op)
      OP_DIV_NN:  begin
        div_start    = 1'b1;
        div_dividend = DW'(modulus_q);
      end
      OP_DIV_GCD: begin
        div_start    = 1'b1;
        div_dividend = DW'(r0_q);
        div_divisor  = r1_q;
      end
      OP_DIV_T:   begin
        div_start    = 1'b1;
        div_dividend = DW'(tv_q);
      end
      OP_DIV_M:   begin
        div_start    = 1'b1;
        div_dividend = DW'(prod_q);
      end
      OP_DIV_S:   begin
        div_start    = 1'b1;
        div_dividend = DW'(prod_q) + DW'(lo_q);
      end
      default: ;
    endcase
  end

  mr_div #(.OW(OW), .DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // Euclid coefficient update and final inverse
  always_comb begin
    qc       = QW'($signed({1'b0, div_quot[OW-1:0]})) * QW'(c1_q);
    c_next   = c0_q - $signed(qc[CW-1:0]);
    rr_s     = $signed(CW'(radix_q));
    v0       = c0_q[CW-1] ? (c0_q + rr_s) : c0_q;
    v1       = (v0 >= rr_s) ? (v0 - rr_s) : v0;
    inv_calc = (v1 == '0) ? '0 : (radix_q - v1[OW-1:0]);
    t_sum    = {1'b0, hi_q} + div_quot[OW:0];
    t_fix    = (t_sum >= {1'b0, modulus_q}) ? (t_sum - {1'b0, modulus_q}) : t_sum;
  end

  // Configuration and cache control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= OW'(2);
      modulus_q     <= OW'(1);
      cache_ready_q <= 1'b0;
      coprime_q     <= 1'b0;
      inv_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        cache_ready_q <= 1'b0;
        if (cfg_reg_e'(cfg_addr_i) == REG_RADIX) begin
          radix_q <= cfg_wdata_i[OW-1:0];
        end else begin
          modulus_q <= cfg_wdata_i[OW-1:0];
        end
      end else if (cmd_i.op == OP_GCD_END) begin
        cache_ready_q <= 1'b1;
        coprime_q     <= (r0_q == OW'(1));
        inv_q         <= (r0_q == OW'(1)) ? inv_calc : '0;
      end else if (cmd_i.op == OP_GCD_FAIL) begin
        cache_ready_q <= 1'b1;
        coprime_q     <= 1'b0;
        inv_q         <= '0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rn_q <= PW'(radix_q) * PW'(modulus_q);
    unique case (cmd_i.op)
      OP_LOAD:        tv_q <= value_t_i;
      OP_GCD_SEED:    begin
        r0_q <= radix_q;
        r1_q <= div_rem;
        c0_q <= '0;
        c1_q <= CW'(1);
      end
      OP_GCD_STEP:    begin
        r0_q <= r1_q;
        r1_q <= div_rem;
        c0_q <= c1_q;
        c1_q <= c_next;
      end
      OP_ERR_COPRIME: begin
        res_q  <= '0;
        stat_q <= STATUS_COPRIME;
      end
      OP_ERR_RANGE:   begin
        res_q  <= '0;
        stat_q <= STATUS_RANGE;
      end
      OP_MUL_M:       begin
        lo_q   <= div_rem;
        hi_q   <= div_quot[OW-1:0];
        prod_q <= PW'(div_rem) * PW'(inv_q);
      end
      OP_MUL_N:       prod_q <= PW'(div_rem) * PW'(modulus_q);
      OP_FINISH:      begin
        res_q  <= t_fix[OW-1:0];
        stat_q <= STATUS_OK;
      end
      OP_EMIT:        begin
        out_q      <= res_q;
        out_stat_q <= stat_q;
      end
      default: ;
    endcase
  end

  assign status_o.div_done     = div_done;
  assign status_o.cache_ready  = cache_ready_q;
  assign status_o.coprime      = coprime_q;
  assign status_o.operand_zero = (radix_q == '0) || (modulus_q == '0);
  assign status_o.r1_zero      = (r1_q == '0);
  assign status_o.t_high       = (tv_q >= ValueWidth'(rn_q));

  assign reduced_o       = CfgWidth'(out_q);
  assign result_status_o = out_stat_q;

endmodule

FILE: rtl/mr_ctrl.sv
// Controller: sequences cache build, range check and the three divisions per word.
module mr_ctrl import mr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = status_i.cache_ready ? ST_CHECK : ST_NN;
      ST_NN:       state_d = status_i.operand_zero ? ST_GCD_FAIL : ST_NN_WAIT;
      ST_NN_WAIT:  if (status_i.div_done) state_d = ST_GCD_TEST;
      ST_GCD_TEST: state_d = status_i.r1_zero ? ST_GCD_END : ST_GCD_WAIT;
      ST_GCD_WAIT: if (status_i.div_done) state_d = ST_GCD_TEST;
      ST_GCD_END:  state_d = ST_CHECK;
      ST_GCD_FAIL: state_d = ST_CHECK;
      ST_CHECK: begin
        priority if (!status_i.coprime) state_d = ST_EMIT;
        else if (status_i.t_high)       state_d = ST_EMIT;
        else                            state_d = ST_T_WAIT;
      end
      ST_T_WAIT:   if (status_i.div_done) state_d = ST_DIV_M;
      ST_DIV_M:    state_d = ST_M_WAIT;
      ST_M_WAIT:   if (status_i.div_done) state_d = ST_DIV_S;
      ST_DIV_S:    state_d = ST_S_WAIT;
      ST_S_WAIT:   if (status_i.div_done) state_d = ST_EMIT;
      ST_EMIT:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_NN:       if (!status_i.operand_zero) cmd_o.op = OP_DIV_NN;
      ST_NN_WAIT:  if (status_i.div_done) cmd_o.op = OP_GCD_SEED;
      ST_GCD_TEST: if (!status_i.r1_zero) cmd_o.op = OP_DIV_GCD;
      ST_GCD_WAIT: if (status_i.div_done) cmd_o.op = OP_GCD_STEP;
      ST_GCD_END:  cmd_o.op = OP_GCD_END;
      ST_GCD_FAIL: cmd_o.op = OP_GCD_FAIL;
      ST_CHECK: begin
        priority if (!status_i.coprime) cmd_o.op = OP_ERR_COPRIME;
        else if (status_i.t_high)       cmd_o.op = OP_ERR_RANGE;
        else                            cmd_o.op = OP_DIV_T;
      end
      ST_T_WAIT:   if (status_i.div_done) cmd_o.op = OP_MUL_M;
      ST_DIV_M:    cmd_o.op = OP_DIV_M;
      ST_M_WAIT:   if (status_i.div_done) cmd_o.op = OP_MUL_N;
      ST_DIV_S:    cmd_o.op = OP_DIV_S;
      ST_S_WAIT:   if (status_i.div_done) cmd_o.op = OP_FINISH;
      ST_EMIT:     if (out_free) cmd_o.op = OP_EMIT;
      default: ;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/montgomery_reduction.sv
// Top level of the Montgomery reduction (REDC) block with a general radix.
//
// Usage: write radix R (index 0) and modulus N (index 1) through cfg_we_i,
// cfg_addr_i and cfg_wdata_i while the block is idle. Each write drops the
// cached inverse. Input words carry T on s_axis; each gives exactly one
// output word on m_axis with T*R^-1 mod N and a status code.
// With the cache valid, a word makes three passes of the bit-serial divider
// plus control states between its accept and the first possible accept of
// its result; the next input word is taken at that same edge, so a new word
// is taken only once the last one is through. Errors skip the divisions.
// The first word after a configuration change also runs extended Euclid on
// the same divider: up to about 24 divisions for W 16.
// One word is in flight at a time; s_axis_tready is high only while idle.
// The output register holds the result while m_axis_tready is low and the
// next word can be taken in the meantime; it waits before overwriting.
// Reset restores R=2, N=1, clears the cache and empties the output.
module montgomery_reduction import mr_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_addr_i,
  input  logic [CfgWidth-1:0]     cfg_wdata_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [ValueWidth-1:0]   s_axis_tdata,   // [31:0] value_t
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata,   // [15:0] reduced, [23:16] zero
  output logic [StatusWidth-1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned OW = (OPERAND_WIDTH < CfgWidth) ? OPERAND_WIDTH : CfgWidth;

  dp_cmd_t             cmd;
  dp_status_t          dp_status;
  logic [CfgWidth-1:0] reduced;
  status_e             res_status;

  mr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  mr_datapath #(.OW(OW)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .value_t_i       (s_axis_tdata),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .reduced_o       (reduced),
    .result_status_o (res_status)
  );

  assign m_axis_tdata = OutDataWidth'(reduced);
  assign m_axis_tuser = res_status;

endmodule

FILE: rtl/mr_checker.sv
// Port-level checker for the Montgomery reduction block, bound to the top level.
module mr_port_checker import mr_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [OutDataWidth-1:0] m_axis_tdata,
  input logic [StatusWidth-1:0]  m_axis_tuser
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // One word in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // Status code stays in range
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status code");

  // Error words carry a zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tdata == '0)
    else $error("error word with nonzero result");

endmodule

bind montgomery_reduction mr_port_checker u_mr_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
